### sv/periodic_event_scheduler_core_assert.svh
// Assertion macros shared by the scheduler checkers.
`ifndef PERIODIC_EVENT_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_EVENT_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define PES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pes: same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define PES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pes: next-cycle check failed");

// next-cycle implication, also active during reset
`define PES_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pes: reset check failed");

`endif

### sv/pes_pkg.sv
// Shared types, codes and helper functions of the periodic event scheduler.
`default_nettype none
package pes_pkg;

    localparam int MAX_CLIENTS_DEF = 64;
    localparam int REQ_W   = 2;
    localparam int ID_W    = 16;
    localparam int PER_W   = 16;
    localparam int TIME_W  = 48;
    localparam int ST_W    = 2;
    localparam int ENTRY_W = TIME_W + ID_W + PER_W;

    localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELIVER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_RESULT  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_ROOT    = 3'd4;
    localparam logic [2:0] OP_UP_MOVE = 3'd5;
    localparam logic [2:0] OP_DN_MOVE = 3'd6;
    localparam logic [2:0] OP_PLACE   = 3'd7;

    // read address selects
    localparam logic [1:0] RD_ROOT   = 2'd0;
    localparam logic [1:0] RD_PARENT = 2'd1;
    localparam logic [1:0] RD_CHILD  = 2'd2;

    // heap entry, ordered by due time, then id, then period
    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  period;
    } t_entry;

    typedef struct packed {
        logic [2:0]      op;
        logic            rd_en;
        logic [1:0]      rd_sel;
        logic [ST_W-1:0] status;
        logic            out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_empty;
        logic cnt_full;
        logic pos_root;
        logic up_move;
        logic has_child;
        logic dn_move;
    } t_dp_stat;

    function automatic logic f_precedes(t_entry a, t_entry b);
        logic [ENTRY_W-1:0] va;
        logic [ENTRY_W-1:0] vb;
        va = a;
        vb = b;
        return va < vb;
    endfunction

    // due time plus period, saturating
    function automatic t_entry f_advance(t_entry e);
        logic [TIME_W:0] sum;
        t_entry          r;
        sum = {1'b0, e.due} + {{(TIME_W - PER_W + 1){1'b0}}, e.period};
        r = e;
        r.due = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/pes_ctrl.sv
// Sequencing state machine of the scheduler: request decode, heap sift steps, result handoff.
`default_nettype none
module pes_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    input  wire [pes_pkg::REQ_W-1:0]     i_req_type,
    output logic                         o_req_stall,
    output logic                         o_rsp_valid,
    input  wire                          i_rsp_stall,
    output pes_pkg::t_dp_cmd             o_cmd,
    input  wire pes_pkg::t_dp_stat       i_stat
);
    import pes_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROOT   = 3'd1;
    localparam logic [2:0] S_UP_RD  = 3'd2;
    localparam logic [2:0] S_UP_CMP = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_POST   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req_type)
                        REQ_ADD: begin
                            if (i_stat.cnt_full) begin
                                w_cmd.op     = OP_RESULT;
                                w_cmd.status = ST_FULL;
                                n_state      = S_POST;
                            end else begin
                                w_cmd.op = OP_ADD;
                                n_state  = S_UP_RD;
                            end
                        end
                        REQ_DELIVER: begin
                            if (i_stat.cnt_empty) begin
                                w_cmd.op     = OP_RESULT;
                                w_cmd.status = ST_EMPTY;
                                n_state      = S_POST;
                            end else begin
                                w_cmd.rd_en  = 1'b1;
                                w_cmd.rd_sel = RD_ROOT;
                                n_state      = S_ROOT;
                            end
                        end
                        REQ_CLEAR: begin
                            w_cmd.op = OP_CLEAR;
                            n_state  = S_POST;
                        end
                        default: begin
                            w_cmd.op     = OP_RESULT;
                            w_cmd.status = ST_OK;
                            n_state      = S_POST;
                        end
                    endcase
                end
            end
            S_ROOT: begin
                w_cmd.op = OP_ROOT;
                n_state  = S_DN_RD;
            end
            S_UP_RD: begin
                if (i_stat.pos_root) begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_POST;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_PARENT;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_move) begin
                    w_cmd.op = OP_UP_MOVE;
                    n_state  = S_UP_RD;
                end else begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_POST;
                end
            end
            S_DN_RD: begin
                if (i_stat.has_child) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_CHILD;
                    n_state      = S_DN_CMP;
                end else begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_POST;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_move) begin
                    w_cmd.op = OP_DN_MOVE;
                    n_state  = S_DN_RD;
                end else begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_POST;
                end
            end
            S_POST: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = w_cmd.out_load | (r_out_valid & i_rsp_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule
`default_nettype wire

### sv/pes_dp.sv
// Heap datapath of the scheduler: entry memory, sift registers, comparators and result registers.
`default_nettype none
module pes_dp #(
    parameter int MAX_CLIENTS = pes_pkg::MAX_CLIENTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire pes_pkg::t_dp_cmd        i_cmd,
    output pes_pkg::t_dp_stat            o_stat,
    input  wire [pes_pkg::ID_W-1:0]      i_client_id,
    input  wire [pes_pkg::PER_W-1:0]     i_client_period,
    output logic [pes_pkg::ID_W-1:0]     o_served_id,
    output logic [pes_pkg::TIME_W-1:0]   o_served_time,
    output logic [pes_pkg::ST_W-1:0]     o_status
);
    import pes_pkg::*;

    localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam int XW = IW + 2;

    t_entry            r_mem [MAX_CLIENTS];
    t_entry            r_rd_a;
    t_entry            r_rd_b;
    t_entry            r_cur;
    logic [IW-1:0]     r_pos;
    logic [CW-1:0]     r_count;

    logic [ID_W-1:0]   r_res_id;
    logic [TIME_W-1:0] r_res_time;
    logic [ST_W-1:0]   r_res_status;
    logic [ID_W-1:0]   r_out_id;
    logic [TIME_W-1:0] r_out_time;
    logic [ST_W-1:0]   r_out_status;

    logic [IW-1:0]     w_pos_dec;
    logic [IW-1:0]     w_parent;
    logic [XW-1:0]     w_c1;
    logic [XW-1:0]     w_c2;
    logic [XW-1:0]     w_cnt_x;
    logic              w_has1;
    logic              w_has2;
    logic [IW-1:0]     w_addr_a;
    logic [IW-1:0]     w_addr_b;
    logic              w_b_lt_a;
    logic              w_a_lt_cur;
    logic              w_b_lt_cur;
    t_entry            w_best;
    logic [IW-1:0]     w_best_idx;
    logic              w_wr_en;
    t_entry            w_wr_data;

    assign w_pos_dec = r_pos - IW'(1);
    assign w_parent  = w_pos_dec >> 1;
    assign w_c1      = {1'b0, r_pos, 1'b1};
    assign w_c2      = w_c1 + XW'(1);
    assign w_cnt_x   = XW'(r_count);
    assign w_has1    = (w_c1 < w_cnt_x);
    assign w_has2    = (w_c2 < w_cnt_x);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ROOT:   w_addr_a = '0;
            RD_PARENT: w_addr_a = w_parent;
            default:   w_addr_a = w_c1[IW-1:0];
        endcase
    end

    assign w_addr_b = ((i_cmd.rd_sel == RD_CHILD) && w_has2) ? w_c2[IW-1:0] : w_addr_a;

    // smaller child and its order against the sifted entry, in parallel
    assign w_b_lt_a   = w_has2 & f_precedes(r_rd_b, r_rd_a);
    assign w_a_lt_cur = f_precedes(r_rd_a, r_cur);
    assign w_b_lt_cur = f_precedes(r_rd_b, r_cur);
    assign w_best     = w_b_lt_a ? r_rd_b : r_rd_a;
    assign w_best_idx = w_b_lt_a ? w_c2[IW-1:0] : w_c1[IW-1:0];

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_data = r_cur;
        case (i_cmd.op)
            OP_UP_MOVE: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_rd_a;
            end
            OP_DN_MOVE: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_best;
            end
            OP_PLACE: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_cur;
            end
            default: begin
                w_wr_en   = 1'b0;
                w_wr_data = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[w_addr_a];
            r_rd_b <= r_mem[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                OP_ADD:   r_count <= r_count + CW'(1);
                OP_CLEAR: r_count <= '0;
                default:  r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ADD: begin
                r_cur.due    <= {{(TIME_W - PER_W){1'b0}}, i_client_period};
                r_cur.id     <= i_client_id;
                r_cur.period <= i_client_period;
                r_pos        <= r_count[IW-1:0];
                r_res_id     <= '0;
                r_res_time   <= '0;
                r_res_status <= ST_OK;
            end
            OP_RESULT: begin
                r_res_id     <= '0;
                r_res_time   <= '0;
                r_res_status <= i_cmd.status;
            end
            OP_CLEAR: begin
                r_res_id     <= '0;
                r_res_time   <= '0;
                r_res_status <= ST_OK;
            end
            OP_ROOT: begin
                r_cur        <= f_advance(r_rd_a);
                r_pos        <= '0;
                r_res_id     <= r_rd_a.id;
                r_res_time   <= r_rd_a.due;
                r_res_status <= ST_OK;
            end
            OP_UP_MOVE: begin
                r_pos <= w_parent;
            end
            OP_DN_MOVE: begin
                r_pos <= w_best_idx;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_id     <= r_res_id;
            r_out_time   <= r_res_time;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.cnt_empty = (r_count == '0);
    assign o_stat.cnt_full  = (r_count == CW'(MAX_CLIENTS));
    assign o_stat.pos_root  = (r_pos == '0);
    assign o_stat.up_move   = f_precedes(r_cur, r_rd_a);
    assign o_stat.has_child = w_has1;
    assign o_stat.dn_move   = w_b_lt_a ? w_b_lt_cur : w_a_lt_cur;

    assign o_served_id   = r_out_id;
    assign o_served_time = r_out_time;
    assign o_status      = r_out_status;

endmodule
`default_nettype wire

### sv/periodic_event_scheduler_core.sv
// Top level of the periodic event scheduler: min-heap of periodic clients.
// Request channel: i_req_valid / o_req_stall carry one item (type, client id,
//   client period). An item is taken on a clock edge with valid high and stall low.
// Response channel: o_rsp_valid / i_rsp_stall carry one result item per request
//   (served id, served time, status) from an output register.
// Add places the client at the heap tail and sifts it up; deliver reads the root,
//   reports it, advances its due time and sifts it down. Clear, error and reserved
//   items finish at once.
// From accept to output register load, clear, error and reserved items go straight to
//   the result step; each heap level walked takes a memory read state, then a compare
//   state.
// One item is in work at a time and the next one is taken the cycle after the
//   load.
// A finished result waits in the output register while the next item is taken;
//   if the receiver stalls long enough, the next result holds the block busy.
// Synchronous active-low reset empties the queue and clears the response valid and the request stall;
//   the entry memory keeps no reset value.
`default_nettype none
module periodic_event_scheduler_core #(
    parameter int MAX_CLIENTS = pes_pkg::MAX_CLIENTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    output logic                         o_req_stall,
    input  wire [pes_pkg::REQ_W-1:0]     i_req_type,
    input  wire [pes_pkg::ID_W-1:0]      i_client_id,
    input  wire [pes_pkg::PER_W-1:0]     i_client_period,
    output logic                         o_rsp_valid,
    input  wire                          i_rsp_stall,
    output logic [pes_pkg::ID_W-1:0]     o_served_id,
    output logic [pes_pkg::TIME_W-1:0]   o_served_time,
    output logic [pes_pkg::ST_W-1:0]     o_status
);
    import pes_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req_type),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    pes_dp #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_client_id     (i_client_id),
        .i_client_period (i_client_period),
        .o_served_id     (o_served_id),
        .o_served_time   (o_served_time),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

### sv/pes_checker.sv
// Port-level checker of the scheduler top level and its bind.
`default_nettype none
`include "periodic_event_scheduler_core_assert.svh"
module pes_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_req_valid,
    input wire                          o_req_stall,
    input wire                          o_rsp_valid,
    input wire                          i_rsp_stall,
    input wire [pes_pkg::ID_W-1:0]      o_served_id,
    input wire [pes_pkg::TIME_W-1:0]    o_served_time,
    input wire [pes_pkg::ST_W-1:0]      o_status
);
    import pes_pkg::*;

    `PES_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_served_id) && $stable(o_served_time) && $stable(o_status))

    `PES_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_rsp_valid && (o_status != ST_OK), (o_served_id == '0) && (o_served_time == '0))

    `PES_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall)

    `PES_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_rsp_valid && !o_req_stall)

endmodule

bind periodic_event_scheduler_core pes_checker u_pes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req_valid),
    .o_req_stall   (o_req_stall),
    .o_rsp_valid   (o_rsp_valid),
    .i_rsp_stall   (i_rsp_stall),
    .o_served_id   (o_served_id),
    .o_served_time (o_served_time),
    .o_status      (o_status)
);
`default_nettype wire
